### src/int_gcd_lcm_with_missing_assert.svh
// assertion macros for the gcd/lcm block
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef INT_GCD_LCM_WITH_MISSING_ASSERT_SVH
`define INT_GCD_LCM_WITH_MISSING_ASSERT_SVH

// property checked on every clock edge outside reset
`define IGL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition that must never be seen
`define IGL_NEVER(lbl, cond, msg) \
  `IGL_ASSERT(lbl, !(cond), msg)

`endif

### src/igl_pkg.sv
// shared types for the gcd/lcm block: sequencer states, op codes,
// and the status bundle of the shared divider. no dependencies
package igl_pkg;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_TEST = 7'b0000010,
    S_RDIV = 7'b0000100,
    S_QDIV = 7'b0001000,
    S_MUL  = 7'b0010000,
    S_CHK  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

  typedef enum logic {
    OP_GCD = 1'b0,
    OP_LCM = 1'b1
  } op_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### src/int_gcd_lcm_with_missing.sv
// gcd / lcm of two signed words with a missing-value code
// uses igl_pkg, igl_div and the assertion macros header
//
// usage:
//   drive op_i, operand_a_i, operand_b_i and raise start; the beat is taken
//   at a clock edge with start high and busy low. busy stays high until the
//   answer has been shown. done_o marks answer_o for exactly one cycle and
//   the receiver must take it then; there is no back pressure.
//   the skip_missing register is written over cfg_valid_i/cfg_data_i (cfg_ready_o
//   is always high); the user must write it only while the block is idle, as the block does not enforce it.
// timing:
//   a missing operand is answered in the cycle right after the accepting edge.
//   otherwise each euclidean remainder step runs one divide in the shared
//   bit-serial divider; a 32-bit gcd needs up to about 46 steps. lcm adds
//   one more divide, a multiply and a range check. one item is in flight at
//   a time.
// reset:
//   asynchronous, active low; the sequencer returns to idle, no answer is
//   pending and skip_missing clears to 0.
module int_gcd_lcm_with_missing #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               op_i,
  input  logic signed [31:0] operand_a_i,
  input  logic signed [31:0] operand_b_i,
  output logic               done_o,
  output logic signed [31:0] answer_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_data_i
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned PW = 2 * WORD_BITS;
  localparam logic [W-1:0] MissWord = {1'b1, {(W-1){1'b0}}};

  igl_pkg::state_e    state_q, state_d;
  igl_pkg::op_e       op_q, op_d;
  logic               skip_q, skip_d;
  logic [W-1:0]       mx_q, mx_d;
  logic [W-1:0]       my_q, my_d;
  logic               sx_q, sx_d;
  logic               sy_q, sy_d;
  logic [W-1:0]       ma_q, ma_d;
  logic [W-1:0]       mb_q, mb_d;
  logic [W-1:0]       quot_q, quot_d;
  logic [PW-1:0]      prod_q, prod_d;
  logic [W-1:0]       answer_q, answer_d;

  logic [W-1:0]       a_w, b_w, a_abs, b_abs;
  logic               a_miss, b_miss;
  logic               div_start;
  logic [W-1:0]       div_dividend, div_divisor;
  logic [W-1:0]       div_quo, div_rem;
  igl_pkg::div_stat_t div_stat;

  assign a_w    = operand_a_i[W-1:0];
  assign b_w    = operand_b_i[W-1:0];
  assign a_miss = a_w == MissWord;
  assign b_miss = b_w == MissWord;
  assign a_abs  = a_w[W-1] ? (~a_w + 1'b1) : a_w;
  assign b_abs  = b_w[W-1] ? (~b_w + 1'b1) : b_w;

  igl_div #(
    .WORD_BITS (W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .stat_o      (div_stat),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    skip_d       = cfg_valid_i ? cfg_data_i : skip_q;
    mx_d         = mx_q;
    my_d         = my_q;
    sx_d         = sx_q;
    sy_d         = sy_q;
    ma_d         = ma_q;
    mb_d         = mb_q;
    quot_d       = quot_q;
    prod_d       = prod_q;
    answer_d     = answer_q;
    div_start    = 1'b0;
    div_dividend = mx_q;
    div_divisor  = my_q;
    unique case (state_q)
      igl_pkg::S_IDLE: begin
        if (start) begin
          op_d = igl_pkg::op_e'(op_i);
          if (a_miss || b_miss) begin
            answer_d = skip_q ? (a_miss ? b_w : a_w) : MissWord;
            state_d  = igl_pkg::S_OUT;
          end else begin
            mx_d    = a_abs;
            sx_d    = a_w[W-1];
            my_d    = b_abs;
            sy_d    = b_w[W-1];
            ma_d    = a_abs;
            mb_d    = b_abs;
            state_d = igl_pkg::S_TEST;
          end
        end
      end
      igl_pkg::S_TEST: begin
        if (my_q == '0) begin
          // euclid finished, mx/sx hold the signed gcd
          if (op_q == igl_pkg::OP_GCD) begin
            answer_d = sx_q ? (~mx_q + 1'b1) : mx_q;
            state_d  = igl_pkg::S_OUT;
          end else if (mx_q == '0) begin
            answer_d = MissWord;
            state_d  = igl_pkg::S_OUT;
          end else begin
            div_start    = 1'b1;
            div_dividend = ma_q;
            div_divisor  = mx_q;
            state_d      = igl_pkg::S_QDIV;
          end
        end else begin
          div_start = 1'b1;
          state_d   = igl_pkg::S_RDIV;
        end
      end
      igl_pkg::S_RDIV: begin
        if (div_stat.done) begin
          // remainder takes the sign of the dividend
          mx_d    = my_q;
          sx_d    = sy_q;
          my_d    = div_rem;
          sy_d    = sx_q;
          state_d = igl_pkg::S_TEST;
        end
      end
      igl_pkg::S_QDIV: begin
        if (div_stat.done) begin
          quot_d  = div_quo;
          state_d = igl_pkg::S_MUL;
        end
      end
      igl_pkg::S_MUL: begin
        prod_d  = PW'(quot_q) * PW'(mb_q);
        state_d = igl_pkg::S_CHK;
      end
      igl_pkg::S_CHK: begin
        if (prod_q[PW-1:W-1] != '0) begin
          answer_d = MissWord;
        end else begin
          answer_d = sx_q ? (~prod_q[W-1:0] + 1'b1) : prod_q[W-1:0];
        end
        state_d = igl_pkg::S_OUT;
      end
      igl_pkg::S_OUT: begin
        state_d = igl_pkg::S_IDLE;
      end
      default: begin
        state_d = igl_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= igl_pkg::S_IDLE;
      skip_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      skip_q  <= skip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    mx_q     <= mx_d;
    my_q     <= my_d;
    sx_q     <= sx_d;
    sy_q     <= sy_d;
    ma_q     <= ma_d;
    mb_q     <= mb_d;
    quot_q   <= quot_d;
    prod_q   <= prod_d;
    answer_q <= answer_d;
  end

  assign busy        = state_q != igl_pkg::S_IDLE;
  assign done_o      = state_q == igl_pkg::S_OUT;
  assign answer_o    = 32'($signed(answer_q));
  assign cfg_ready_o = 1'b1;

`include "int_gcd_lcm_with_missing_assert.svh"

  `IGL_ASSERT(a_done_then_idle, done_o |=> !busy, "answer beat not followed by idle")
  `IGL_ASSERT(a_accept_busy, start && !busy |=> busy, "accepted beat did not raise busy")
  `IGL_ASSERT(a_div_done_waited, div_stat.done |-> (state_q == igl_pkg::S_RDIV || state_q == igl_pkg::S_QDIV), "divider finished with no step waiting")
  `IGL_NEVER(a_div_restart, div_start && div_stat.busy, "divider restarted while busy")

endmodule

### src/igl_div.sv
// shared restoring divider: one quotient bit per cycle on unsigned words
// uses igl_pkg::div_stat_t for its status
module igl_div #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [WORD_BITS-1:0]  dividend_i,
  input  logic [WORD_BITS-1:0]  divisor_i,
  output igl_pkg::div_stat_t    stat_o,
  output logic [WORD_BITS-1:0]  quotient_o,
  output logic [WORD_BITS-1:0]  remainder_o
);

  localparam int unsigned CntW = $clog2(WORD_BITS + 1);

  logic [WORD_BITS-1:0] rem_q, rem_d;
  logic [WORD_BITS-1:0] quo_q, quo_d;
  logic [WORD_BITS-1:0] dvs_q, dvs_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [WORD_BITS:0]   trial;
  logic [WORD_BITS:0]   diff;
  logic                 fits;

  // shift in the next dividend bit and try to subtract
  assign trial = {rem_q, quo_q[WORD_BITS-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = CntW'(WORD_BITS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
      quo_d = {quo_q[WORD_BITS-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy  = busy_q;
  assign stat_o.done  = done_q;
  assign quotient_o   = quo_q;
  assign remainder_o  = rem_q;

endmodule
